// File: design/m3i_pkg.sv
// package: widths and fraction bits for the 3x3 matrix inverse
package m3i_pkg;
    localparam int ElementWidth = 16;
    localparam int FractionBits = 8;
endpackage

// File: design/m3i_divider.sv
// pipelined restoring divider: one quotient bit per stage, truncation toward zero
module m3i_divider #(
    parameter int NumWidth = 51,
    parameter int DenWidth = 49,
    parameter int OutWidth = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [NumWidth-1:0] i_num,
    input  logic signed [DenWidth-1:0] i_den,
    output logic                       o_valid,
    output logic signed [OutWidth-1:0] o_quot,
    output logic                       o_clip
);
    import m3i_pkg::*;

    // magnitude quotient is limited to OutWidth bits plus one overflow detect bit
    localparam int QBits = OutWidth + 1;
    localparam int MagW  = NumWidth;
    localparam int RemW  = DenWidth + 1;

    logic             r_v   [QBits+1];
    logic [MagW-1:0]  r_num [QBits+1];
    logic [RemW-1:0]  r_den [QBits+1];
    logic [RemW-1:0]  r_rem [QBits+1];
    logic [QBits-1:0] r_q   [QBits+1];
    logic             r_neg [QBits+1];
    logic             r_ovf [QBits+1];

    logic [MagW-1:0] n_anum;
    logic [RemW-1:0] n_aden;

    always_comb begin
        n_anum = i_num[NumWidth-1] ? MagW'(-i_num) : MagW'(i_num);
        n_aden = i_den[DenWidth-1] ? RemW'(-$signed({i_den[DenWidth-1], i_den}))
                                   : RemW'({1'b0, i_den});
    end

    // stage 0: magnitudes; high numerator bits above QBits compared at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_num[0] <= n_anum << (MagW - QBits);
        r_den[0] <= n_aden;
        // high part of numerator (above the low QBits bits) must be below the divisor
        r_rem[0] <= RemW'(n_anum >> QBits);
        r_ovf[0] <= (n_anum >> QBits) >= MagW'(n_aden);
        r_q[0]   <= '0;
        r_neg[0] <= i_num[NumWidth-1] ^ i_den[DenWidth-1];
    end

    for (genvar s = 0; s < QBits; s++) begin : g_stage
        logic [RemW:0] n_trial;
        logic [RemW:0] n_diff;
        always_comb begin
            n_trial = {r_rem[s], r_num[s][MagW-1]};
            n_diff  = n_trial - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_num[s+1] <= r_num[s] << 1;
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
            if (!n_diff[RemW]) begin
                r_rem[s+1] <= n_diff[RemW-1:0];
                r_q[s+1]   <= {r_q[s][QBits-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_trial[RemW-1:0];
                r_q[s+1]   <= {r_q[s][QBits-2:0], 1'b0};
            end
        end
    end

    localparam logic [QBits-1:0] PosMax = QBits'((1 << (OutWidth - 1)) - 1);
    localparam logic [QBits-1:0] NegMax = QBits'(1 << (OutWidth - 1));

    logic [QBits-1:0] n_mag;
    logic             n_big;
    always_comb begin
        n_mag = r_q[QBits];
        n_big = r_ovf[QBits] || (r_neg[QBits] ? (n_mag > NegMax) : (n_mag > PosMax));
        o_valid = r_v[QBits];
        o_clip  = n_big;
        if (n_big) begin
            o_quot = r_neg[QBits] ? OutWidth'(NegMax) : OutWidth'(PosMax);
        end else begin
            o_quot = r_neg[QBits] ? OutWidth'(-n_mag) : OutWidth'(n_mag);
        end
    end
endmodule

// File: design/matrix3x3_inverse.sv
// top level: 3x3 matrix inverse by the adjugate, pipelined
// One matrix is accepted in any cycle (busy is always low). Its result shows on the
// outputs with a one-cycle o_valid strobe. The path is four stages ahead of the
// dividers, ELEMENT_WIDTH + 2 stages in each divider and the output register,
// and the first stage loads on the accepting edge itself. The receiver cannot stall,
// so nothing backs up. Latency is set by the nine bit-per-stage dividers, one
// quotient bit each stage. Products are 2x2 minors (one multiplier per register),
// then the determinant terms, then the sum.
module matrix3x3_inverse #(
    parameter int ELEMENT_WIDTH = m3i_pkg::ElementWidth,
    parameter int FRACTION_BITS = m3i_pkg::FractionBits
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m00, i_m01, i_m02,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m10, i_m11, i_m12,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m20, i_m21, i_m22,
    output logic                            o_valid,
    output logic signed [ELEMENT_WIDTH-1:0] o_inv00, o_inv01, o_inv02,
    output logic signed [ELEMENT_WIDTH-1:0] o_inv10, o_inv11, o_inv12,
    output logic signed [ELEMENT_WIDTH-1:0] o_inv20, o_inv21, o_inv22,
    output logic signed [3*ELEMENT_WIDTH:0] o_determinant,
    output logic                            o_singular,
    output logic                            o_saturated
);
    import m3i_pkg::*;

    localparam int EW   = ELEMENT_WIDTH;
    localparam int PW   = 2 * EW;          // one product
    localparam int CW   = 2 * EW + 1;      // cofactor
    localparam int DW   = 3 * EW + 1;      // determinant
    localparam int NW   = CW + 2 * FRACTION_BITS; // shifted numerator
    localparam int DLAT = EW + 2;          // divider latency

    assign busy = 1'b0;

    // stage 1: the eighteen products of the minors
    logic signed [EW-1:0] a [9];
    assign a = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};

    // index pairs (a*b - c*d) per adjugate entry, row-major
    localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic signed [PW-1:0] r_p [9];
    logic signed [PW-1:0] r_q [9];
    logic signed [EW-1:0] r_a0 [3];
    logic signed [CW-1:0] r_cof [9];
    logic signed [EW-1:0] r_a1 [3];
    logic signed [DW-1:0] r_t [3];
    logic signed [CW-1:0] r_cof3 [9];
    logic signed [DW-1:0] r_det;
    logic signed [CW-1:0] r_cof4 [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        for (int k = 0; k < 9; k++) begin
            r_p[k]    <= a[IA[k]] * a[IB[k]];
            r_q[k]    <= a[IC[k]] * a[ID[k]];
            // stage 2: cofactors
            r_cof[k]  <= CW'(r_p[k]) - CW'(r_q[k]);
            r_cof3[k] <= r_cof[k];
            r_cof4[k] <= r_cof3[k];
        end
        for (int k = 0; k < 3; k++) begin
            r_a0[k] <= a[k];
            r_a1[k] <= r_a0[k];
            // stage 3: first-row times first-column cofactors
            r_t[k]  <= DW'(r_a1[k] * r_cof[3*k]);
        end
        // stage 4: determinant sum
        r_det <= r_t[0] + r_t[1] + r_t[2];
    end

    // dividers: cofactor << 2F over the determinant
    logic                 n_dv   [9];
    logic signed [EW-1:0] n_quot [9];
    logic                 n_clip [9];

    for (genvar k = 0; k < 9; k++) begin : g_div
        m3i_divider #(.NumWidth(NW), .DenWidth(DW), .OutWidth(EW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v4 && (r_det != '0)),
            .i_num   ({r_cof4[k], {(2*FRACTION_BITS){1'b0}}}),
            .i_den   (r_det),
            .o_valid (n_dv[k]),
            .o_quot  (n_quot[k]),
            .o_clip  (n_clip[k])
        );
    end

    // delay determinant and valid alongside the dividers
    logic             r_dv [DLAT];
    logic [DW-1:0]    r_dd [DLAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DLAT; s++) r_dv[s] <= 1'b0;
        end else begin
            r_dv[0] <= r_v4;
            for (int s = 1; s < DLAT; s++) r_dv[s] <= r_dv[s-1];
        end
        r_dd[0] <= r_det;
        for (int s = 1; s < DLAT; s++) r_dd[s] <= r_dd[s-1];
    end

    // output register: zero inverse when singular
    logic             r_ov, r_sing, r_sat;
    logic [DW-1:0]    r_odet;
    logic [EW-1:0]    r_inv [9];
    logic             n_sing, n_sat;
    always_comb begin
        n_sing = (r_dd[DLAT-1] == '0);
        n_sat  = 1'b0;
        for (int k = 0; k < 9; k++) n_sat = n_sat | n_clip[k];
        n_sat = n_sat & !n_sing;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_dv[DLAT-1];
        r_odet <= r_dd[DLAT-1];
        r_sing <= n_sing;
        r_sat  <= n_sat;
        for (int k = 0; k < 9; k++) r_inv[k] <= n_sing ? '0 : n_quot[k];
    end

    assign o_valid       = r_ov;
    assign o_determinant = r_odet;
    assign o_singular    = r_sing;
    assign o_saturated   = r_sat;
    assign o_inv00 = r_inv[0];
    assign o_inv01 = r_inv[1];
    assign o_inv02 = r_inv[2];
    assign o_inv10 = r_inv[3];
    assign o_inv11 = r_inv[4];
    assign o_inv12 = r_inv[5];
    assign o_inv20 = r_inv[6];
    assign o_inv21 = r_inv[7];
    assign o_inv22 = r_inv[8];
endmodule

// File: design/m3i_checker.sv
// port checker for the matrix inverse, bound to the top level
module m3i_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic        o_singular,
    input logic        o_saturated,
    input logic [15:0] o_inv00,
    input logic [48:0] o_determinant
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_singular == (o_determinant == '0)))
        else $error("singular flag and determinant disagree");
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated)
        else $error("saturated with singular");
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_inv00 == '0)
        else $error("nonzero inverse for singular");
endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .o_valid(o_valid),
    .o_singular(o_singular), .o_saturated(o_saturated), .o_inv00(o_inv00),
    .o_determinant(o_determinant)
);
